// ----- hdl/bppmi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bppmi_pkg
// Shared types and fixed field widths of the binary pixel-pair mutual
// information core.
// ----------------------------------------------------------------------------
package bppmi_pkg;

    localparam int BITS_W   = 64;
    localparam int SIDE_W   = 4;
    localparam int TOTAL_W  = 27;
    localparam int SD_W     = 16;
    localparam int USED_W   = 20;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd4;
    localparam logic [SIDE_W-1:0] SIDE_MIN   = 4'd2;

    typedef struct packed {
        logic [BITS_W-1:0] window_bits;
        logic              last_window;
    } t_in;

    typedef struct packed {
        logic [TOTAL_W-1:0] mi_sum;
        logic [SD_W-1:0]    mi_std_dev;
        logic [USED_W-1:0]  windows_used;
        logic               count_overflow;
    } t_out;

    // accumulate pipeline: one read-modify-write in flight
    typedef struct packed {
        logic valid;
        logic is_pix;
        logic inc;
    } t_acc_stage;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_ACC_DRAIN,
        ST_EV_RD,
        ST_EV_START,
        ST_EV_RUN,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_VAR_RD,
        ST_VAR_SQ,
        ST_VAR_ACC,
        ST_VDIV_GO,
        ST_VDIV_WAIT,
        ST_SQRT,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        PE_IDLE,
        PE_CELL,
        PE_MUL,
        PE_NORM,
        PE_SQR,
        PE_TERM,
        PE_ACC,
        PE_FIN,
        PE_DIV_WAIT,
        PE_DONE
    } t_pe_state;

endpackage
`default_nettype wire

// ----- hdl/bppmi_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bppmi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bppmi_div #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   sh;
    logic             fits;
    logic [DEN_W:0]   diff;

    always_comb begin
        sh   = {r_rem, r_q[NUM_W-1]};
        fits = (sh >= {1'b0, r_den});
        diff = sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_q   <= {r_q[NUM_W-2:0], fits};
                r_rem <= fits ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// ----- hdl/bppmi_pair_eval.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bppmi_pair_eval
// Mutual information of one pixel pair from its window, pixel and joint
// counts: two fixed-point logs per cell with nonzero counts by repeated
// squaring, exact term sums, and a division by the window count when positive.
// ----------------------------------------------------------------------------
module bppmi_pair_eval #(
    parameter int COUNT_BITS = 20,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [COUNT_BITS-1:0] i_n,
    input  wire logic [COUNT_BITS-1:0] i_a,
    input  wire logic [COUNT_BITS-1:0] i_b,
    input  wire logic [COUNT_BITS-1:0] i_c,
    output logic                       o_done,
    output logic [FRAC_BITS:0]         o_value
);

    localparam int CW     = COUNT_BITS;
    localparam int MI_W   = FRAC_BITS + 1;
    localparam int LOG_W  = 6 + FRAC_BITS;
    localparam int TM_W   = CW + LOG_W;
    localparam int ACC_W  = TM_W + 2;
    localparam int STEP_W = $clog2(FRAC_BITS);

    bppmi_pkg::t_pe_state r_state, n_state;

    logic [CW-1:0]     r_n, r_a, r_b, r_c;
    logic [1:0]        r_k;
    logic              r_second;
    logic [63:0]       r_v;
    logic [5:0]        r_e;
    logic [STEP_W-1:0] r_step;
    logic [31:0]       r_m;
    logic [FRAC_BITS-1:0] r_frac;
    logic [LOG_W-1:0]  r_l1, r_l2;
    logic [TM_W-1:0]   r_tm;
    logic              r_tneg;
    logic [ACC_W-1:0]  r_pos, r_neg;
    logic [MI_W-1:0]   r_value;

    logic [CW-1:0]     cnt, mx, my;
    logic              skip;
    logic [2*CW-1:0]   prod;
    logic [6:0]        sh_amt;
    logic              top_zero;
    logic [63:0]       v_next;
    logic [5:0]        e_next;
    logic [63:0]       sq;
    logic [32:0]       sq_t;
    logic [31:0]       m_next;
    logic [FRAC_BITS-1:0] frac_next;
    logic [LOG_W-1:0]  log_val;
    logic [LOG_W:0]    d;
    logic [LOG_W-1:0]  mag;
    logic [TM_W-1:0]   tm_c;
    logic              positive;
    logic              div_start;
    logic              div_done;
    logic [ACC_W-1:0]  div_quot;

    always_comb begin
        case (r_k)
            2'd0: begin
                cnt = r_n - r_a - r_b + r_c;
                mx  = r_n - r_a;
                my  = r_n - r_b;
            end
            2'd1: begin
                cnt = r_a - r_c;
                mx  = r_a;
                my  = r_n - r_b;
            end
            2'd2: begin
                cnt = r_b - r_c;
                mx  = r_n - r_a;
                my  = r_b;
            end
            default: begin
                cnt = r_c;
                mx  = r_a;
                my  = r_b;
            end
        endcase
        skip = (cnt == '0) || (mx == '0) || (my == '0);
        prod = r_second ? (mx * my) : (cnt * r_n);

        // leading-zero search: halve the shift each step
        sh_amt   = 7'd32 >> r_step;
        top_zero = ((r_v >> (7'd64 - sh_amt)) == 64'd0);
        v_next   = top_zero ? (r_v << sh_amt) : r_v;
        e_next   = top_zero ? (r_e - sh_amt[5:0]) : r_e;

        sq        = r_m * r_m;
        sq_t      = sq[63:31];
        m_next    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
        frac_next = {r_frac[FRAC_BITS-2:0], sq_t[32]};
        log_val   = {r_e, frac_next};

        d    = {1'b0, r_l1} - {1'b0, r_l2};
        mag  = d[LOG_W] ? LOG_W'(-d) : d[LOG_W-1:0];
        tm_c = TM_W'(cnt) * TM_W'(mag);

        positive = (r_pos > r_neg) && (r_n != '0);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bppmi_pkg::PE_IDLE:     if (i_start) n_state = bppmi_pkg::PE_CELL;
            bppmi_pkg::PE_CELL: begin
                if (!skip)            n_state = bppmi_pkg::PE_MUL;
                else if (r_k == 2'd3) n_state = bppmi_pkg::PE_FIN;
            end
            bppmi_pkg::PE_MUL:      n_state = bppmi_pkg::PE_NORM;
            bppmi_pkg::PE_NORM:     if (r_step == STEP_W'(5)) n_state = bppmi_pkg::PE_SQR;
            bppmi_pkg::PE_SQR: begin
                if (r_step == STEP_W'(FRAC_BITS - 1))
                    n_state = r_second ? bppmi_pkg::PE_TERM : bppmi_pkg::PE_MUL;
            end
            bppmi_pkg::PE_TERM:     n_state = bppmi_pkg::PE_ACC;
            bppmi_pkg::PE_ACC:
                n_state = (r_k == 2'd3) ? bppmi_pkg::PE_FIN : bppmi_pkg::PE_CELL;
            bppmi_pkg::PE_FIN:
                n_state = positive ? bppmi_pkg::PE_DIV_WAIT : bppmi_pkg::PE_DONE;
            bppmi_pkg::PE_DIV_WAIT: if (div_done) n_state = bppmi_pkg::PE_DONE;
            bppmi_pkg::PE_DONE:     n_state = bppmi_pkg::PE_IDLE;
            default:                n_state = bppmi_pkg::PE_IDLE;
        endcase
    end

    always_comb begin
        div_start = (r_state == bppmi_pkg::PE_FIN) && positive;
        o_done    = (r_state == bppmi_pkg::PE_DONE);
        o_value   = r_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bppmi_pkg::PE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            bppmi_pkg::PE_IDLE: begin
                if (i_start) begin
                    r_n   <= i_n;
                    r_a   <= i_a;
                    r_b   <= i_b;
                    r_c   <= i_c;
                    r_k   <= 2'd0;
                    r_pos <= '0;
                    r_neg <= '0;
                end
            end
            bppmi_pkg::PE_CELL: begin
                r_second <= 1'b0;
                if (skip) r_k <= r_k + 2'd1;
            end
            bppmi_pkg::PE_MUL: begin
                r_v    <= 64'(prod);
                r_e    <= 6'd63;
                r_step <= '0;
            end
            bppmi_pkg::PE_NORM: begin
                r_v <= v_next;
                r_e <= e_next;
                if (r_step == STEP_W'(5)) begin
                    r_m    <= v_next[63:32];
                    r_frac <= '0;
                    r_step <= '0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            bppmi_pkg::PE_SQR: begin
                r_m    <= m_next;
                r_frac <= frac_next;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(FRAC_BITS - 1)) begin
                    if (r_second) begin
                        r_l2 <= log_val;
                    end else begin
                        r_l1     <= log_val;
                        r_second <= 1'b1;
                    end
                end
            end
            bppmi_pkg::PE_TERM: begin
                r_tm   <= tm_c;
                r_tneg <= d[LOG_W];
            end
            bppmi_pkg::PE_ACC: begin
                if (r_tneg) r_neg <= r_neg + ACC_W'(r_tm);
                else        r_pos <= r_pos + ACC_W'(r_tm);
                r_k <= r_k + 2'd1;
            end
            bppmi_pkg::PE_FIN: begin
                if (!positive) r_value <= '0;
            end
            bppmi_pkg::PE_DIV_WAIT: begin
                if (div_done) begin
                    if (div_quot > (ACC_W'(1) << FRAC_BITS))
                        r_value <= MI_W'(1) << FRAC_BITS;
                    else
                        r_value <= div_quot[MI_W-1:0];
                end
            end
            default: ;
        endcase
    end

    bppmi_div #(
        .NUM_W (ACC_W),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_pos - r_neg),
        .i_den   (r_n),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

endmodule
`default_nettype wire

// ----- hdl/binary_pixel_pair_mutual_info_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// binary_pixel_pair_mutual_info_core
// Counts per-pixel and joint ones over a set of binary windows and reports
// the summed pairwise mutual information and its standard deviation.
// ----------------------------------------------------------------------------
// Usage: raise start with a window on i_req while busy is low; the request is
// taken on that edge. i_cfg_we/i_cfg_wdata set the window side; the user
// writes it only while idle, which the block itself does not enforce. A
// counted window visits each of its pixel and pair counters in turn: one is
// read per cycle through the count memories and, when its bits are set,
// incremented and written back. A dropped window (count full) leaves the
// counts as they are. The window marked last also runs the evaluation: a
// log/divide pass per pair, a variance pass per pair, two serial divides and
// a serial square root. The result is shown for one cycle on o_result with
// o_strobe high; the receiver cannot stall it. A clearing pass then zeroes
// the count memories with busy high.
// After reset the same clearing pass runs before the first request is taken.
// ----------------------------------------------------------------------------
module binary_pixel_pair_mutual_info_core #(
    parameter int MAX_SIDE   = 8,
    parameter int COUNT_BITS = 20,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire bppmi_pkg::t_in                  i_req,
    output logic                                 o_strobe,
    output bppmi_pkg::t_out                      o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [bppmi_pkg::SIDE_W-1:0]    i_cfg_wdata
);

    localparam int CW      = COUNT_BITS;
    localparam int NPIX    = MAX_SIDE * MAX_SIDE;
    localparam int NPAIR   = NPIX * (NPIX - 1) / 2;
    localparam int PIX_AW  = $clog2(NPIX);
    localparam int PAIR_AW = $clog2(NPAIR);
    localparam int NP_W    = $clog2(NPAIR + 1);
    localparam int MI_W    = FRAC_BITS + 1;
    localparam int TOT_W   = MI_W + NP_W;
    localparam int VAR_W   = 2 * MI_W + NP_W;
    localparam int SQ_W    = VAR_W + (VAR_W % 2);
    localparam int SW      = bppmi_pkg::SIDE_W;
    localparam logic [CW-1:0] COUNT_MAX = '1;

    // memories
    logic [CW-1:0]   pair_mem [NPAIR];
    logic [CW-1:0]   pix_mem  [NPIX];
    logic [MI_W-1:0] mi_mem   [NPAIR];

    bppmi_pkg::t_state     r_state, n_state;
    bppmi_pkg::t_acc_stage r_s1;

    logic [SW-1:0]      r_side;
    logic [CW-1:0]      r_wt;
    logic               r_ovf;
    logic [63:0]        r_bits;
    logic               r_last;
    logic [PIX_AW-1:0]  r_q_m1;
    logic [NP_W-1:0]    r_np;
    logic [PIX_AW-1:0]  r_f, r_h;
    logic [PAIR_AW-1:0] r_idx;
    logic [PIX_AW-1:0]  r_s1_paddr;
    logic [PAIR_AW-1:0] r_s1_qaddr;
    logic [CW-1:0]      r_pair_rd, r_pix_rd_a, r_pix_rd_b;
    logic [MI_W-1:0]    r_mi_rd;
    logic [TOT_W-1:0]   r_total;
    logic [MI_W-1:0]    r_mean;
    logic [2*MI_W-1:0]  r_sq;
    logic [VAR_W-1:0]   r_var;
    logic [SQ_W-1:0]    r_sv, r_sr, r_sb;

    logic [SW-1:0]      side_eff;
    logic [2*SW-1:0]    q_c;
    logic [4*SW-1:0]    np_c;
    logic               accept;
    logic               can_count;
    logic               idx_last;
    logic               acc_last;
    logic               pair_we, pix_we, mi_we;
    logic [PAIR_AW-1:0] pair_waddr;
    logic [CW-1:0]      pair_wdata;
    logic [PIX_AW-1:0]  pix_waddr;
    logic [CW-1:0]      pix_wdata;
    logic               pe_start, pe_done;
    logic [MI_W-1:0]    pe_value;
    logic               div_start, div_done;
    logic [VAR_W-1:0]   div_num, div_quot;
    logic [MI_W-1:0]    dev;
    logic [SQ_W-1:0]    sq_sum;
    logic               sq_fit;
    logic [TOT_W+bppmi_pkg::TOTAL_W-1:0] tot_ext;
    logic [SQ_W+bppmi_pkg::SD_W-1:0]     sd_ext;
    logic [CW+bppmi_pkg::USED_W-1:0]     wt_ext;

    always_comb begin
        if (r_side < bppmi_pkg::SIDE_MIN)  side_eff = bppmi_pkg::SIDE_MIN;
        else if (r_side > SW'(MAX_SIDE))   side_eff = SW'(MAX_SIDE);
        else                               side_eff = r_side;
        q_c       = side_eff * side_eff;
        np_c      = ((4*SW)'(q_c) * ((4*SW)'(q_c) - 1'b1)) >> 1;
        accept    = start && (r_state == bppmi_pkg::ST_IDLE);
        can_count = (r_wt < COUNT_MAX);
        idx_last  = (r_idx == PAIR_AW'(r_np - 1'b1));
        acc_last  = (r_h == r_f) && (r_f == r_q_m1);
        dev       = (r_mi_rd > r_mean) ? (r_mi_rd - r_mean) : (r_mean - r_mi_rd);
        sq_sum    = r_sr + r_sb;
        sq_fit    = (r_sv >= sq_sum);
        tot_ext   = (TOT_W+bppmi_pkg::TOTAL_W)'(r_total);
        sd_ext    = (SQ_W+bppmi_pkg::SD_W)'(r_sr);
        wt_ext    = (CW+bppmi_pkg::USED_W)'(r_wt);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bppmi_pkg::ST_CLEAR:
                if (r_idx == PAIR_AW'(NPAIR - 1)) n_state = bppmi_pkg::ST_IDLE;
            bppmi_pkg::ST_IDLE: begin
                if (accept) begin
                    if (can_count)              n_state = bppmi_pkg::ST_ACC;
                    else if (i_req.last_window) n_state = bppmi_pkg::ST_EV_RD;
                end
            end
            bppmi_pkg::ST_ACC:       if (acc_last) n_state = bppmi_pkg::ST_ACC_DRAIN;
            bppmi_pkg::ST_ACC_DRAIN:
                n_state = r_last ? bppmi_pkg::ST_EV_RD : bppmi_pkg::ST_IDLE;
            bppmi_pkg::ST_EV_RD:     n_state = bppmi_pkg::ST_EV_START;
            bppmi_pkg::ST_EV_START:  n_state = bppmi_pkg::ST_EV_RUN;
            bppmi_pkg::ST_EV_RUN: begin
                if (pe_done)
                    n_state = idx_last ? bppmi_pkg::ST_MEAN_GO : bppmi_pkg::ST_EV_RD;
            end
            bppmi_pkg::ST_MEAN_GO:   n_state = bppmi_pkg::ST_MEAN_WAIT;
            bppmi_pkg::ST_MEAN_WAIT: if (div_done) n_state = bppmi_pkg::ST_VAR_RD;
            bppmi_pkg::ST_VAR_RD:    n_state = bppmi_pkg::ST_VAR_SQ;
            bppmi_pkg::ST_VAR_SQ:    n_state = bppmi_pkg::ST_VAR_ACC;
            bppmi_pkg::ST_VAR_ACC:
                n_state = idx_last ? bppmi_pkg::ST_VDIV_GO : bppmi_pkg::ST_VAR_RD;
            bppmi_pkg::ST_VDIV_GO:   n_state = bppmi_pkg::ST_VDIV_WAIT;
            bppmi_pkg::ST_VDIV_WAIT: if (div_done) n_state = bppmi_pkg::ST_SQRT;
            bppmi_pkg::ST_SQRT:      if (r_sb[0]) n_state = bppmi_pkg::ST_OUT;
            bppmi_pkg::ST_OUT:       n_state = bppmi_pkg::ST_CLEAR;
            default:                 n_state = bppmi_pkg::ST_CLEAR;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        busy       = (r_state != bppmi_pkg::ST_IDLE);
        o_strobe   = (r_state == bppmi_pkg::ST_OUT);
        pe_start   = (r_state == bppmi_pkg::ST_EV_START);
        div_start  = (r_state == bppmi_pkg::ST_MEAN_GO) || (r_state == bppmi_pkg::ST_VDIV_GO);
        div_num    = (r_state == bppmi_pkg::ST_MEAN_GO) ? VAR_W'(r_total) : r_var;
        mi_we      = (r_state == bppmi_pkg::ST_EV_RUN) && pe_done;

        pair_we    = 1'b0;
        pair_waddr = r_s1_qaddr;
        pair_wdata = r_pair_rd + 1'b1;
        pix_we     = 1'b0;
        pix_waddr  = r_s1_paddr;
        pix_wdata  = r_pix_rd_b + 1'b1;
        if (r_state == bppmi_pkg::ST_CLEAR) begin
            pair_we    = 1'b1;
            pair_waddr = r_idx;
            pair_wdata = '0;
            pix_we     = (r_idx < PAIR_AW'(NPIX));
            pix_waddr  = r_idx[PIX_AW-1:0];
            pix_wdata  = '0;
        end else if (r_s1.valid && r_s1.inc) begin
            pair_we = !r_s1.is_pix;
            pix_we  = r_s1.is_pix;
        end

        o_result.mi_sum = (tot_ext > (TOT_W+bppmi_pkg::TOTAL_W)'({bppmi_pkg::TOTAL_W{1'b1}}))
                          ? {bppmi_pkg::TOTAL_W{1'b1}} : tot_ext[bppmi_pkg::TOTAL_W-1:0];
        o_result.mi_std_dev = (sd_ext > (SQ_W+bppmi_pkg::SD_W)'({bppmi_pkg::SD_W{1'b1}}))
                          ? {bppmi_pkg::SD_W{1'b1}} : sd_ext[bppmi_pkg::SD_W-1:0];
        o_result.windows_used = (wt_ext > (CW+bppmi_pkg::USED_W)'({bppmi_pkg::USED_W{1'b1}}))
                          ? {bppmi_pkg::USED_W{1'b1}} : wt_ext[bppmi_pkg::USED_W-1:0];
        o_result.count_overflow = r_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (pair_we) pair_mem[pair_waddr] <= pair_wdata;
        r_pair_rd <= pair_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (pix_we) pix_mem[pix_waddr] <= pix_wdata;
        r_pix_rd_a <= pix_mem[r_h];
        r_pix_rd_b <= pix_mem[r_f];
    end

    always_ff @(posedge i_clk) begin
        if (mi_we) mi_mem[r_idx] <= pe_value;
        r_mi_rd <= mi_mem[r_idx];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bppmi_pkg::ST_CLEAR;
            r_side     <= bppmi_pkg::SIDE_RESET;
            r_wt       <= '0;
            r_ovf      <= 1'b0;
            r_idx      <= '0;
            r_s1.valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1.valid <= (r_state == bppmi_pkg::ST_ACC);
            if (i_cfg_we) r_side <= i_cfg_wdata;
            case (r_state)
                bppmi_pkg::ST_CLEAR: r_idx <= r_idx + 1'b1;
                bppmi_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_idx <= '0;
                        if (can_count) r_wt  <= r_wt + 1'b1;
                        else           r_ovf <= 1'b1;
                    end
                end
                bppmi_pkg::ST_ACC: begin
                    r_s1.is_pix <= (r_h == r_f);
                    r_s1.inc    <= (r_h == r_f) ? r_bits[r_f] : (r_bits[r_f] & r_bits[r_h]);
                    if (r_h != r_f) r_idx <= r_idx + 1'b1;
                end
                bppmi_pkg::ST_ACC_DRAIN: r_idx <= '0;
                bppmi_pkg::ST_EV_RUN:    if (pe_done && !idx_last) r_idx <= r_idx + 1'b1;
                bppmi_pkg::ST_MEAN_WAIT: if (div_done) r_idx <= '0;
                bppmi_pkg::ST_VAR_ACC:   if (!idx_last) r_idx <= r_idx + 1'b1;
                bppmi_pkg::ST_OUT: begin
                    r_wt  <= '0;
                    r_ovf <= 1'b0;
                    r_idx <= '0;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            bppmi_pkg::ST_IDLE: begin
                if (accept) begin
                    r_bits  <= i_req.window_bits;
                    r_last  <= i_req.last_window;
                    r_q_m1  <= PIX_AW'(q_c - 1'b1);
                    r_np    <= NP_W'(np_c);
                    r_f     <= can_count ? PIX_AW'(0) : PIX_AW'(1);
                    r_h     <= '0;
                    r_total <= '0;
                end
            end
            bppmi_pkg::ST_ACC: begin
                r_s1_paddr  <= r_f;
                r_s1_qaddr  <= r_idx;
                if (r_h == r_f) begin
                    r_f <= r_f + 1'b1;
                    r_h <= '0;
                end else begin
                    r_h <= r_h + 1'b1;
                end
            end
            bppmi_pkg::ST_ACC_DRAIN: begin
                r_f     <= PIX_AW'(1);
                r_h     <= '0;
                r_total <= '0;
            end
            bppmi_pkg::ST_EV_RUN: begin
                if (pe_done) begin
                    r_total <= r_total + TOT_W'(pe_value);
                    if (r_h == r_f - 1'b1) begin
                        r_f <= r_f + 1'b1;
                        r_h <= '0;
                    end else begin
                        r_h <= r_h + 1'b1;
                    end
                end
            end
            bppmi_pkg::ST_MEAN_WAIT: begin
                if (div_done) begin
                    r_mean <= div_quot[MI_W-1:0];
                    r_var  <= '0;
                end
            end
            bppmi_pkg::ST_VAR_SQ:  r_sq  <= dev * dev;
            bppmi_pkg::ST_VAR_ACC: r_var <= r_var + VAR_W'(r_sq);
            bppmi_pkg::ST_VDIV_WAIT: begin
                if (div_done) begin
                    r_sv <= SQ_W'(div_quot);
                    r_sr <= '0;
                    r_sb <= SQ_W'(1) << (SQ_W - 2);
                end
            end
            bppmi_pkg::ST_SQRT: begin
                if (sq_fit) begin
                    r_sv <= r_sv - sq_sum;
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb <= r_sb >> 2;
            end
            default: ;
        endcase
    end

    bppmi_pair_eval #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_pair_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pe_start),
        .i_n     (r_wt),
        .i_a     (r_pix_rd_a),
        .i_b     (r_pix_rd_b),
        .i_c     (r_pair_rd),
        .o_done  (pe_done),
        .o_value (pe_value)
    );

    bppmi_div #(
        .NUM_W (VAR_W),
        .DEN_W (NP_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_np),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // a dropped window that is not last leaves the block idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || r_ovf))
        else $error("request accepted but block not busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> (!o_strobe && r_state == bppmi_pkg::ST_CLEAR))
        else $error("result not followed by clearing pass");

    a_wb_in_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.valid |-> (r_state == bppmi_pkg::ST_ACC || r_state == bppmi_pkg::ST_ACC_DRAIN))
        else $error("count write-back outside accumulate");

    a_eval_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pe_done |-> (r_state == bppmi_pkg::ST_EV_RUN))
        else $error("pair value finished outside evaluation");

endmodule
`default_nettype wire

// ----- test/tb_binary_pixel_pair_mutual_info_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_pixel_pair_mutual_info_core
// Sends binary windows to the mutual information core and compares each
// reported data set summary with a behavioral model kept in the testbench.
// ----------------------------------------------------------------------------
module tb_binary_pixel_pair_mutual_info_core;

    localparam int NPIX       = 64;
    localparam int NPAIR      = 2016;
    localparam int COUNT_MAX  = (1 << 20) - 1;
    localparam int FRAC       = 16;
    localparam int SETTLE_CYC = 2300;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    bppmi_pkg::t_in                i_req = '0;
    logic                          o_strobe;
    bppmi_pkg::t_out               o_result;
    logic                          i_cfg_we = 1'b0;
    logic [bppmi_pkg::SIDE_W-1:0]  i_cfg_wdata = '0;

    binary_pixel_pair_mutual_info_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model state
    int unsigned                   joint_ones [NPAIR];
    int unsigned                   pix_ones [NPIX];
    longint unsigned               pair_mi [NPAIR];
    int unsigned                   win_count;
    bit                            dropped_seen;
    logic [bppmi_pkg::SIDE_W-1:0]  side_reg;

    bppmi_pkg::t_out     summary_q [$];
    int                  err_count;
    int                  windows_sent;
    int                  summaries_seen;
    int                  idle_pct;

    function automatic longint log2_fix(longint unsigned x);
        int              e;
        longint unsigned m;
        longint          frac;
        e = 63;
        frac = 0;
        if (x == 0) return 0;
        while (x[e] == 1'b0) e--;
        if (e >= 31) m = x >> (e - 31);
        else m = x << (31 - e);
        for (int k = 0; k < FRAC; k++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (longint'(e) << FRAC) + frac;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned pair_info(longint unsigned n, longint unsigned a,
                                                  longint unsigned b, longint unsigned c);
        longint unsigned cnt [4];
        longint unsigned mx [4];
        longint unsigned my [4];
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned qv;
        longint          d;
        pos = 0;
        neg = 0;
        cnt[0] = n - a - b + c; mx[0] = n - a; my[0] = n - b;
        cnt[1] = a - c;         mx[1] = a;     my[1] = n - b;
        cnt[2] = b - c;         mx[2] = n - a; my[2] = b;
        cnt[3] = c;             mx[3] = a;     my[3] = b;
        for (int k = 0; k < 4; k++) begin
            if (cnt[k] != 0 && mx[k] != 0 && my[k] != 0) begin
                d = log2_fix(cnt[k] * n) - log2_fix(mx[k] * my[k]);
                if (d > 0) pos += cnt[k] * longint'(d);
                else neg += cnt[k] * longint'(-d);
            end
        end
        if (pos <= neg || n == 0) return 0;
        qv = (pos - neg) / n;
        if (qv > (64'd1 << FRAC)) qv = 64'd1 << FRAC;
        return qv;
    endfunction

    task automatic clear_counts();
        foreach (joint_ones[i]) joint_ones[i] = 0;
        foreach (pix_ones[i]) pix_ones[i] = 0;
        win_count = 0;
        dropped_seen = 0;
    endtask

    // update the model with one accepted window; queue a summary on the last one
    task automatic count_window(bppmi_pkg::t_in req);
        int              side;
        int              q;
        int              np;
        int              idx;
        logic [63:0]     bits;
        longint unsigned n;
        longint unsigned total;
        longint unsigned mean;
        longint unsigned var_sum;
        longint unsigned dev;
        longint unsigned v;
        bppmi_pkg::t_out res;
        side = side_reg;
        if (side < 2) side = 2;
        if (side > 8) side = 8;
        q = side * side;
        bits = req.window_bits;
        if (q < 64) bits &= (64'd1 << q) - 1;
        if (win_count < COUNT_MAX) begin
            win_count++;
            for (int f = 0; f < q; f++) begin
                if (bits[f]) begin
                    pix_ones[f]++;
                    for (int h = 0; h < f; h++)
                        if (bits[h]) joint_ones[f * (f - 1) / 2 + h]++;
                end
            end
        end else begin
            dropped_seen = 1;
        end
        if (!req.last_window) return;
        n = win_count;
        total = 0;
        np = 0;
        var_sum = 0;
        for (int f = 1; f < q; f++) begin
            for (int h = 0; h < f; h++) begin
                idx = f * (f - 1) / 2 + h;
                pair_mi[idx] = pair_info(n, pix_ones[h], pix_ones[f], joint_ones[idx]);
                total += pair_mi[idx];
                np++;
            end
        end
        mean = total / np;
        for (int f = 1; f < q; f++) begin
            for (int h = 0; h < f; h++) begin
                v = pair_mi[f * (f - 1) / 2 + h];
                v = v > mean ? v - mean : mean - v;
                var_sum += v * v;
            end
        end
        dev = isqrt(var_sum / np);
        res.mi_sum         = total > 64'h7FFFFFF ? 27'h7FFFFFF : total[26:0];
        res.mi_std_dev     = dev > 64'hFFFF ? 16'hFFFF : dev[15:0];
        res.windows_used   = n > 64'hFFFFF ? 20'hFFFFF : n[19:0];
        res.count_overflow = dropped_seen;
        summary_q.push_back(res);
        clear_counts();
    endtask

    always @(posedge i_clk) begin
        bppmi_pkg::t_out exp_res;
        if (i_rst_n && o_strobe) begin
            summaries_seen++;
            if (summary_q.size() == 0) begin
                $error("unexpected result mi_sum=%0d", o_result.mi_sum);
                err_count++;
            end else begin
                exp_res = summary_q.pop_front();
                if (o_result.mi_sum !== exp_res.mi_sum) begin
                    $error("mi_sum expected %0d actual %0d",
                           exp_res.mi_sum, o_result.mi_sum);
                    err_count++;
                end
                if (o_result.mi_std_dev !== exp_res.mi_std_dev) begin
                    $error("mi_std_dev expected %0d actual %0d",
                           exp_res.mi_std_dev, o_result.mi_std_dev);
                    err_count++;
                end
                if (o_result.windows_used !== exp_res.windows_used) begin
                    $error("windows_used expected %0d actual %0d",
                           exp_res.windows_used, o_result.windows_used);
                    err_count++;
                end
                if (o_result.count_overflow !== exp_res.count_overflow) begin
                    $error("count_overflow expected %0d actual %0d",
                           exp_res.count_overflow, o_result.count_overflow);
                    err_count++;
                end
            end
        end
    end

    task automatic send_window(logic [63:0] bits, logic last);
        bppmi_pkg::t_in req;
        req.window_bits = bits;
        req.last_window = last;
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        @(negedge i_clk);
        start = 1'b1;
        i_req = req;
        do @(posedge i_clk); while (busy);
        count_window(req);
        windows_sent++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // wait out pending results plus the longest internal pass
    task automatic settle();
        while (summary_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic write_side(logic [bppmi_pkg::SIDE_W-1:0] side);
        settle();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = side;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        side_reg = side;
    endtask

    function automatic logic [63:0] rand_bits();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(5))
            0: b = b & {$urandom, $urandom};
            1: b = b | {$urandom, $urandom};
            2: b = $urandom_range(1) ? '0 : '1;
            default: ;
        endcase
        return b;
    endfunction

    task automatic test_default_side();
        send_window('0, 1'b1);
        send_window('1, 1'b0);
        send_window('1, 1'b0);
        send_window(64'h0000_0000_0000_A5A5, 1'b0);
        send_window('0, 1'b1);
    endtask

    task automatic test_side_extremes();
        write_side(4'd2);
        send_window('1, 1'b1);
        send_window(64'h5, 1'b0);
        send_window(64'hA, 1'b0);
        send_window(64'hFFFF_FFFF_FFFF_FFF3, 1'b1);
        write_side(4'd0);
        send_window(64'h9, 1'b0);
        send_window(64'h6, 1'b1);
        write_side(4'd1);
        send_window(64'h3, 1'b1);
        // above the largest side: runs as the largest side
        write_side(4'd15);
        send_window(64'hF0F0_F0F0_0F0F_0F0F, 1'b0);
        send_window(64'h8000_0000_0000_0001, 1'b1);
    endtask

    task automatic test_side_change_mid_set();
        write_side(4'd8);
        send_window('1, 1'b0);
        send_window(64'hAAAA_AAAA_5555_5555, 1'b0);
        // counts already made are kept across the side change
        write_side(4'd2);
        send_window(64'h7, 1'b1);
        write_side(4'd3);
        send_window(64'h1FF, 1'b0);
        write_side(4'd4);
        send_window(64'h1234, 1'b1);
    endtask

    task automatic test_random(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            if (summary_q.size() == 0 && $urandom_range(3) == 0) begin
                pick = $urandom_range(99);
                if (pick < 60) write_side(4'd2);
                else if (pick < 85) write_side(4'd3);
                else if (pick < 95) write_side(4'd4);
                else write_side(4'($urandom_range(1)));
            end
            send_window(rand_bits(), $urandom_range(4) == 0);
        end
        send_window(rand_bits(), 1'b1);
    endtask

    initial begin
        err_count = 0;
        windows_sent = 0;
        summaries_seen = 0;
        idle_pct = 35;
        side_reg = bppmi_pkg::SIDE_RESET;
        clear_counts();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_default_side();
        test_side_extremes();
        test_side_change_mid_set();
        test_random(90);
        idle_pct = 78;
        test_random(90);
        idle_pct = 0;
        test_random(90);
        settle();
        $display("Sent %0d windows, checked %0d data set summaries over sides 0..15.",
                 windows_sent, summaries_seen);
        $display("Covered idle rates of 35, 78 and 0 percent and mid-set side changes.");
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- binary_pixel_pair_mutual_info_core.f -----
hdl/bppmi_pkg.sv
hdl/bppmi_div.sv
hdl/bppmi_pair_eval.sv
hdl/binary_pixel_pair_mutual_info_core.sv
test/tb_binary_pixel_pair_mutual_info_core.sv
